// ===== rtl/mwm_pkg.sv =====
package mwm_pkg;

    localparam int CMD_W    = 16;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 4;
    localparam int WHL_W    = 33;
    localparam int MAG_W    = 31;
    localparam int PROD_W   = MAG_W + CFG_W;
    localparam int QUO_W    = 16;
    localparam int REM_W    = MAG_W + 1;
    localparam int DIV_STG  = 8;
    localparam int STEPS    = QUO_W / DIV_STG;
    localparam int NWHEEL   = 4;

    localparam logic signed [CMD_W-1:0] ONE_Q14 = 16'sd16384;
    localparam logic [MAG_W-1:0]        ONE_Q22 = 31'd4194304;

    localparam logic [IDX_W-1:0] REG_TURN_GAIN = 4'd0;
    localparam logic [IDX_W-1:0] REG_PWM_SCALE = 4'd1;

    localparam logic [CFG_W-1:0] TURN_GAIN_RST = 16'd512;
    localparam logic [CFG_W-1:0] PWM_SCALE_RST = 16'd255;

    function automatic logic signed [CMD_W-1:0] clamp_q14(input logic signed [CMD_W-1:0] v);
        logic signed [CMD_W-1:0] r;
        r = v;
        if (v > ONE_Q14)
            r = ONE_Q14;
        else if (v < -ONE_Q14)
            r = -ONE_Q14;
        return r;
    endfunction

endpackage

// ===== rtl/mwm_div.sv =====
module mwm_div
    import mwm_pkg::*;
(
    input  logic              clk,
    input  logic              ce,
    input  logic [PROD_W-1:0] num,
    input  logic [MAG_W-1:0]  den,
    input  logic              neg,
    output logic [QUO_W-1:0]  quo,
    output logic              quo_neg
);

    // stage 0 is the input, stage s+1 the register after s
    logic [MAG_W-1:0]  rem_st [0:DIV_STG];
    logic [QUO_W-1:0]  low_st [0:DIV_STG];
    logic [QUO_W-1:0]  quo_st [0:DIV_STG];
    logic [MAG_W-1:0]  den_st [0:DIV_STG];
    logic              neg_st [0:DIV_STG];

    // quotient never exceeds 16 bits, so the upper part starts below den
    assign rem_st[0] = num[PROD_W-1:QUO_W];
    assign low_st[0] = num[QUO_W-1:0];
    assign quo_st[0] = '0;
    assign den_st[0] = den;
    assign neg_st[0] = neg;

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        logic [MAG_W-1:0] rem_next;
        logic [QUO_W-1:0] low_next;
        logic [QUO_W-1:0] quo_next;
        logic [MAG_W-1:0] rem_reg;
        logic [QUO_W-1:0] low_reg;
        logic [QUO_W-1:0] quo_reg;
        logic [MAG_W-1:0] den_reg;
        logic             neg_reg;

        always_comb
        begin
            logic [REM_W-1:0] t;
            rem_next = rem_st[s];
            low_next = low_st[s];
            quo_next = quo_st[s];
            for (int k = 0; k < STEPS; k++)
            begin
                t = {rem_next, low_next[QUO_W-1]};
                low_next = {low_next[QUO_W-2:0], 1'b0};
                if (t >= {1'b0, den_st[s]})
                begin
                    t = t - {1'b0, den_st[s]};
                    quo_next = {quo_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    quo_next = {quo_next[QUO_W-2:0], 1'b0};
                end
                rem_next = t[MAG_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (ce)
            begin
                rem_reg <= rem_next;
                low_reg <= low_next;
                quo_reg <= quo_next;
                den_reg <= den_st[s];
                neg_reg <= neg_st[s];
            end
        end

        assign rem_st[s+1] = rem_reg;
        assign low_st[s+1] = low_reg;
        assign quo_st[s+1] = quo_reg;
        assign den_st[s+1] = den_reg;
        assign neg_st[s+1] = neg_reg;
    end

    assign quo     = quo_st[DIV_STG];
    assign quo_neg = neg_st[DIV_STG];

endmodule

// ===== rtl/mecanum_wheel_mixer_top.sv =====
// throughput: one command per cycle unless a held result stalls the pipe;
// each wheel has an 8-stage divider taking two quotient bits per stage, so
// a new command enters every cycle while the pipe is not stalled
// reset: asynchronous active-low, clears valid bits, turn_gain to 2.0 and
// pwm_full_scale to 255
module mecanum_wheel_mixer_top
    import mwm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [CMD_W-1:0] forward_speed,
    input  logic signed [CMD_W-1:0] side_speed,
    input  logic signed [CMD_W-1:0] turn_rate,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [CFG_W-1:0]        front_left_fwd_duty,
    output logic [CFG_W-1:0]        front_left_rev_duty,
    output logic [CFG_W-1:0]        back_left_fwd_duty,
    output logic [CFG_W-1:0]        back_left_rev_duty,
    output logic [CFG_W-1:0]        front_right_fwd_duty,
    output logic [CFG_W-1:0]        front_right_rev_duty,
    output logic [CFG_W-1:0]        back_right_fwd_duty,
    output logic [CFG_W-1:0]        back_right_rev_duty
);

    localparam int NVLD = 3 + DIV_STG + 1;

    logic [CFG_W-1:0] gain_reg;
    logic [CFG_W-1:0] scale_reg;
    logic             ce;
    logic [NVLD-1:0]  vld_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= TURN_GAIN_RST;
            scale_reg <= PWM_SCALE_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_TURN_GAIN)
                gain_reg <= cfg_data;
            else if (cfg_index == REG_PWM_SCALE)
                scale_reg <= cfg_data;
        end
    end

    // whole pipe moves together unless a finished result is held
    assign ce       = !(vld_reg[NVLD-1] && out_stall);
    assign in_stall = !ce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (ce)
            vld_reg <= {vld_reg[NVLD-2:0], in_valid};
    end

    // stage 1: clamp, sum and difference, turn product
    logic signed [CMD_W:0]   sum_reg;
    logic signed [CMD_W:0]   dif_reg;
    logic signed [WHL_W-1:0] kt_reg;

    always_ff @(posedge clk)
    begin
        logic signed [CMD_W-1:0] vx;
        logic signed [CMD_W-1:0] vy;
        logic signed [CMD_W-1:0] wz;
        if (ce)
        begin
            vx = clamp_q14(forward_speed);
            vy = clamp_q14(side_speed);
            wz = clamp_q14(turn_rate);
            sum_reg <= (CMD_W+1)'(vx) + (CMD_W+1)'(vy);
            dif_reg <= (CMD_W+1)'(vx) - (CMD_W+1)'(vy);
            kt_reg  <= $signed({1'b0, gain_reg}) * wz;
        end
    end

    // stage 2: wheel values in units of 2^-22
    logic [MAG_W-1:0] mag_reg [NWHEEL];
    logic             neg_reg [NWHEEL];

    always_ff @(posedge clk)
    begin
        logic signed [WHL_W-1:0] s8;
        logic signed [WHL_W-1:0] d8;
        logic signed [WHL_W-1:0] w [NWHEEL];
        if (ce)
        begin
            s8 = WHL_W'(sum_reg) <<< 8;
            d8 = WHL_W'(dif_reg) <<< 8;
            w[0] = s8 + kt_reg;
            w[1] = d8 + kt_reg;
            w[2] = d8 - kt_reg;
            w[3] = s8 - kt_reg;
            for (int i = 0; i < NWHEEL; i++)
            begin
                neg_reg[i] <= w[i][WHL_W-1];
                mag_reg[i] <= w[i][WHL_W-1] ? MAG_W'(-w[i]) : MAG_W'(w[i]);
            end
        end
    end

    // stage 3: denominator and scaled magnitudes
    logic [PROD_W-1:0] prod_reg [NWHEEL];
    logic              sgn_reg  [NWHEEL];
    logic [MAG_W-1:0]  den_reg;

    always_ff @(posedge clk)
    begin
        logic [MAG_W-1:0] m01;
        logic [MAG_W-1:0] m23;
        logic [MAG_W-1:0] mx;
        if (ce)
        begin
            m01 = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
            m23 = (mag_reg[2] > mag_reg[3]) ? mag_reg[2] : mag_reg[3];
            mx  = (m01 > m23) ? m01 : m23;
            den_reg <= (mx > ONE_Q22) ? mx : ONE_Q22;
            for (int i = 0; i < NWHEEL; i++)
            begin
                prod_reg[i] <= PROD_W'(mag_reg[i]) * PROD_W'(scale_reg);
                sgn_reg[i]  <= neg_reg[i];
            end
        end
    end

    logic [QUO_W-1:0] quo   [NWHEEL];
    logic             q_neg [NWHEEL];

    for (genvar i = 0; i < NWHEEL; i++) begin : g_whl
        mwm_div u_div (
            .clk     (clk),
            .ce      (ce),
            .num     (prod_reg[i]),
            .den     (den_reg),
            .neg     (sgn_reg[i]),
            .quo     (quo[i]),
            .quo_neg (q_neg[i])
        );
    end

    // output: saturate and split into bridge duties
    logic [CFG_W-1:0] fwd_reg [NWHEEL];
    logic [CFG_W-1:0] rev_reg [NWHEEL];

    always_ff @(posedge clk)
    begin
        logic [CFG_W-1:0] m;
        if (ce)
        begin
            for (int i = 0; i < NWHEEL; i++)
            begin
                m = (quo[i] > scale_reg) ? scale_reg : quo[i];
                fwd_reg[i] <= q_neg[i] ? '0 : m;
                rev_reg[i] <= q_neg[i] ? m : '0;
            end
        end
    end

    assign out_valid            = vld_reg[NVLD-1];
    assign front_left_fwd_duty  = fwd_reg[0];
    assign front_left_rev_duty  = rev_reg[0];
    assign back_left_fwd_duty   = fwd_reg[1];
    assign back_left_rev_duty   = rev_reg[1];
    assign front_right_fwd_duty = fwd_reg[2];
    assign front_right_rev_duty = rev_reg[2];
    assign back_right_fwd_duty  = fwd_reg[3];
    assign back_right_rev_duty  = rev_reg[3];

    a_no_dual_drive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (front_left_fwd_duty == '0 || front_left_rev_duty == '0))
        else $error("front-left driven both ways");

    a_duty_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (back_right_fwd_duty <= scale_reg && back_right_rev_duty <= scale_reg))
        else $error("duty above full scale");

    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");

endmodule
